FILE: sv/first_fit_block_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FFBA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffba: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffba: next-cycle check failed");

`endif

FILE: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, constants and helper functions of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS  = 128;
  localparam int BLOCK_BYTES = 10;

  // request / response field widths
  localparam int CMD_W    = 2;
  localparam int SIZE_W   = 11;
  localparam int ADDR_W   = 11;
  localparam int STATUS_W = 2;
  localparam int BLK_W    = 8;
  localparam int BYTE_W   = 11;
  localparam int TOTAL_W  = 8;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(102);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

  // divide by BLOCK_BYTES through a reciprocal, exact over DIV_IN_W bits
  localparam int DIV_IN_W = $clog2(2**SIZE_W + BLOCK_BYTES - 1);
  localparam int DIV_SH   = DIV_IN_W + $clog2(BLOCK_BYTES);
  localparam int DIV_M    = (2**DIV_SH + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int DIV_M_W  = $clog2(DIV_M + 1);
  localparam int DIV_P_W  = DIV_IN_W + DIV_M_W;
  localparam int Q_W      = $clog2((2**SIZE_W + BLOCK_BYTES - 2) / BLOCK_BYTES + 1);

  localparam int CMP_W = (Q_W + 1 > CNT_W + 1) ? Q_W + 1 : CNT_W + 1;
  localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
  localparam int MUL_W = CNT_W + BB_W + BYTE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_RANGE_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_COUNT  = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_SET    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_CHECK,
    S_MARK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic             start;
    logic             shift;
    mode_e            mode;
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
    logic [CNT_W-1:0] n;
    logic [Q_W-1:0]   need;
  } scan_ctrl_t;

  typedef struct packed {
    logic             last;
    logic             found;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] used;
  } scan_stat_t;

  function automatic logic [Q_W-1:0] div_bb(logic [DIV_IN_W-1:0] x);
    logic [DIV_P_W-1:0] p;
    p = DIV_P_W'(x) * DIV_P_W'(DIV_M);
    return Q_W'(p >> DIV_SH);
  endfunction

  function automatic logic [BYTE_W-1:0] to_bytes(logic [CNT_W-1:0] x);
    logic [MUL_W-1:0] p;
    p = MUL_W'(x) * MUL_W'(BLOCK_BYTES);
    return p[BYTE_W-1:0];
  endfunction

  function automatic logic [BLK_W-1:0] to_blk(logic [CNT_W-1:0] x);
    logic [CNT_W+BLK_W-1:0] t;
    t = (CNT_W + BLK_W)'(x);
    return t[BLK_W-1:0];
  endfunction

endpackage

FILE: sv/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba interfaces
// Request, response and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_req_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] size_bytes;
  logic [ADDR_W-1:0] address;

  modport source (output valid, command, size_bytes, address, input ready);
  modport sink   (input valid, command, size_bytes, address, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   start_address;
  logic [BLK_W-1:0]    free_blocks;
  logic [BLK_W-1:0]    used_blocks;
  logic [BYTE_W-1:0]   free_bytes;
  logic [BYTE_W-1:0]   used_bytes;

  modport source (output valid, status, start_address, free_blocks, used_blocks,
                  free_bytes, used_bytes, input ready);
  modport sink   (input valid, status, start_address, free_blocks, used_blocks,
                  free_bytes, used_bytes, output ready);
endinterface

interface ffba_cfg_if import ffba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: sv/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One used bit of the block map; passes its bit down the ring on shift.
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic d_i,
  output logic q_o
);

  logic used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= d_i;
    end
  end

  assign q_o = used_q;

endmodule

FILE: sv/ffba_scan.sv
// ----------------------------------------------------------------------------
// ffba_scan
// Ring head: sees one block per cycle in ascending order while the ring shifts,
// runs the first-fit search, sets or clears a block window and counts used blocks.
// ----------------------------------------------------------------------------
module ffba_scan import ffba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_ctrl_t ctrl_i,
  input  logic       bit_i,
  output logic       bit_o,
  output scan_stat_t stat_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [IDX_W-1:0] run_start_q, run_start_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [CNT_W-1:0] used_q, used_d;

  logic [CMP_W-1:0] idx_x;
  logic [CMP_W-1:0] run_inc;
  logic             in_range;
  logic             in_win;
  logic             free_here;
  logic             hit;
  logic [IDX_W-1:0] cur_start;
  logic             wb;

  always_comb begin
    idx_x     = CMP_W'(idx_q);
    in_range  = idx_x < CMP_W'(ctrl_i.n);
    in_win    = (idx_x >= ctrl_i.lo) && (idx_x < ctrl_i.hi);
    free_here = in_range && !bit_i;
    run_inc   = CMP_W'(run_q) + CMP_W'(1);
    cur_start = (run_q == '0) ? idx_q : run_start_q;
    hit       = (ctrl_i.mode == MODE_SEARCH) && !found_q && free_here &&
                (run_inc == CMP_W'(ctrl_i.need));

    case (ctrl_i.mode)
      MODE_SET:   wb = bit_i | in_win;
      MODE_CLEAR: wb = bit_i & ~in_win;
      default:    wb = bit_i;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    run_d       = run_q;
    run_start_d = run_start_q;
    found_d     = found_q;
    first_d     = first_q;
    used_d      = used_q;
    if (ctrl_i.start) begin
      run_d   = '0;
      found_d = 1'b0;
      used_d  = '0;
    end else if (ctrl_i.shift) begin
      idx_d       = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
      run_d       = free_here ? CNT_W'(run_inc) : '0;
      run_start_d = cur_start;
      used_d      = used_q + CNT_W'(in_range & wb);
      if (hit) begin
        found_d = 1'b1;
        first_d = cur_start;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      run_q   <= '0;
      found_q <= 1'b0;
      used_q  <= '0;
    end else begin
      idx_q   <= idx_d;
      run_q   <= run_d;
      found_q <= found_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_start_q <= run_start_d;
    first_q     <= first_d;
  end

  assign bit_o        = wb;
  assign stat_o.last  = ctrl_i.shift && (idx_q == LAST_IDX);
  assign stat_o.found = found_q;
  assign stat_o.first = first_q;
  assign stat_o.idx   = idx_q;
  assign stat_o.used  = used_q;

endmodule

FILE: sv/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit contiguous allocator over a bitmap of fixed-size blocks.
// ----------------------------------------------------------------------------
// The used bits sit in a ring of MAX_BLOCKS cells that rotates one position a
// cycle past a single scan head while the core scans or marks, so every request
// costs one full rotation of the ring plus a setup state and a result state. A
// free, a usage query and a zero-size allocate go from setup through the
// rotation to the result. Any other allocate passes a check state after the
// rotation and, if it found space, needs a second rotation to mark the run it
// found before the result.
// A result that waits on the response side holds the core in its result
// cycle until the response register is free. One request is in work at a
// time; the response register lets the next request enter while a result
// is still waiting. Configuration writes are always ready and are used as soon
// as they are registered, also by a request in work.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_core_defines.svh"

module first_fit_block_allocator_core import ffba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffba_req_if.sink   req_i,
  ffba_cfg_if.sink   cfg_i,
  ffba_rsp_if.source rsp_o
);

  state_e state_q, state_d;

  logic [TOTAL_W-1:0] total_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [Q_W-1:0]     need_q;
  logic [Q_W-1:0]     first_q;
  mode_e              mode_q, mode_d;
  logic [CMP_W-1:0]   lo_q, lo_d;
  logic [CMP_W-1:0]   hi_q, hi_d;
  status_e            status_q, status_d;
  logic [IDX_W-1:0]   start_blk_q, start_blk_d;

  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [BYTE_W-1:0]   rsp_start_q;
  logic [BLK_W-1:0]    rsp_free_q;
  logic [BLK_W-1:0]    rsp_used_q;
  logic [BYTE_W-1:0]   rsp_free_bytes_q;
  logic [BYTE_W-1:0]   rsp_used_bytes_q;

  logic             req_fire;
  logic             rsp_load;
  logic             scan_start;
  logic             scan_shift;
  logic             range_bad;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] free_cnt;

  scan_ctrl_t       scan_ctrl;
  scan_stat_t       scan_stat;
  logic             head_bit;
  logic             head_wb;
  logic [MAX_BLOCKS-1:0] ring;

  // managed block count: register clamped to the map size
  assign n = (CMP_W'(total_q) > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(total_q);

  assign range_bad = (CMP_W'(first_q) + CMP_W'(need_q)) > CMP_W'(n);
  assign free_cnt  = n - scan_stat.used;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      total_q <= cfg_i.data;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_fire) state_d = S_PREP;
      S_PREP:   state_d = S_SCAN;
      S_SCAN:   if (scan_stat.last) state_d = (mode_q == MODE_SEARCH) ? S_CHECK : S_RESULT;
      S_CHECK:  state_d = scan_stat.found ? S_MARK : S_RESULT;
      S_MARK:   if (scan_stat.last) state_d = S_RESULT;
      S_RESULT: if (!rsp_valid_q || rsp_o.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    mode_d      = mode_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    status_d    = status_q;
    start_blk_d = start_blk_q;
    scan_start  = 1'b0;
    scan_shift  = 1'b0;
    rsp_load    = 1'b0;
    unique case (state_q)
      S_PREP: begin
        scan_start  = 1'b1;
        status_d    = ST_OK;
        start_blk_d = '0;
        mode_d      = MODE_COUNT;
        lo_d        = CMP_W'(first_q);
        hi_d        = CMP_W'(first_q) + CMP_W'(need_q);
        case (cmd_q)
          CMD_ALLOC: if (need_q != '0) mode_d = MODE_SEARCH;
          CMD_FREE: begin
            if (range_bad) status_d = ST_RANGE_ERR;
            else           mode_d   = MODE_CLEAR;
          end
          default: mode_d = MODE_COUNT;
        endcase
      end
      S_SCAN, S_MARK: scan_shift = 1'b1;
      S_CHECK: begin
        if (scan_stat.found) begin
          scan_start  = 1'b1;
          mode_d      = MODE_SET;
          lo_d        = CMP_W'(scan_stat.first);
          hi_d        = CMP_W'(scan_stat.first) + CMP_W'(need_q);
          start_blk_d = scan_stat.first;
        end else begin
          status_d = ST_NO_SPACE;
        end
      end
      S_RESULT: rsp_load = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_COUNT;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      if (rsp_load)         rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q   <= req_i.command;
      need_q  <= div_bb(DIV_IN_W'(req_i.size_bytes) + DIV_IN_W'(BLOCK_BYTES - 1));
      first_q <= div_bb(DIV_IN_W'(req_i.address));
    end
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    status_q    <= status_d;
    start_blk_q <= start_blk_d;
    if (rsp_load) begin
      rsp_status_q     <= status_q;
      rsp_start_q      <= to_bytes(CNT_W'(start_blk_q));
      rsp_free_q       <= to_blk(free_cnt);
      rsp_used_q       <= to_blk(scan_stat.used);
      rsp_free_bytes_q <= to_bytes(free_cnt);
      rsp_used_bytes_q <= to_bytes(scan_stat.used);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.start_address = rsp_start_q;
  assign rsp_o.free_blocks   = rsp_free_q;
  assign rsp_o.used_blocks   = rsp_used_q;
  assign rsp_o.free_bytes    = rsp_free_bytes_q;
  assign rsp_o.used_bytes    = rsp_used_bytes_q;

  // ---------------- scan head and cell ring ----------------
  assign scan_ctrl.start = scan_start;
  assign scan_ctrl.shift = scan_shift;
  assign scan_ctrl.mode  = mode_q;
  assign scan_ctrl.lo    = lo_q;
  assign scan_ctrl.hi    = hi_q;
  assign scan_ctrl.n     = n;
  assign scan_ctrl.need  = need_q;

  assign head_bit = ring[0];

  ffba_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .bit_i  (head_bit),
    .bit_o  (head_wb),
    .stat_o (scan_stat)
  );

  // cell k takes the bit of cell k+1; the head writes back into the top cell
  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic d;
    if (k == MAX_BLOCKS - 1) begin : g_top
      assign d = head_wb;
    end else begin : g_mid
      assign d = ring[k+1];
    end
    ffba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (scan_shift),
      .d_i     (d),
      .q_o     (ring[k])
    );
  end

  // ---------------- assertions ----------------
  `FFBA_ASSERT_NOW(a_busy_blocks_req, state_q != S_IDLE, !req_i.ready)
  `FFBA_ASSERT_NOW(a_ring_aligned_idle, state_q == S_IDLE, scan_stat.idx == '0)
  `FFBA_ASSERT_NEXT(a_found_goes_mark, state_q == S_CHECK && scan_stat.found, state_q == S_MARK)
  `FFBA_ASSERT_NOW(a_used_within_n, state_q == S_RESULT, scan_stat.used <= n)

endmodule
